// ----- rtl/dvdd_pkg.sv -----
// -----------------------------------------------------------------------------
// dvdd_pkg
// Shared types, constants and calendar helpers for the date check and
// day count unit.
// -----------------------------------------------------------------------------
package dvdd_pkg;

  localparam int unsigned DAY_W   = 6;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  // day number of 31 Dec 16383 is below 2^23
  localparam int unsigned DN_W    = 23;
  // quotient widths of year/100 and year/400 for years below 2^14 (+399)
  localparam int unsigned Q100_W  = 8;
  localparam int unsigned Q400_W  = 6;

  localparam logic [YEAR_W-1:0]  YEAR_LO_RST = 14'd2022;
  localparam logic [YEAR_W-1:0]  YEAR_HI_RST = 14'd2050;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_YEAR_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YEAR_HI = 2'd1;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [CODE_W-1:0] {
    ST_OK         = 2'd0,
    ST_START_BAD  = 2'd1,
    ST_END_BAD    = 2'd2,
    ST_END_BEFORE = 2'd3
  } status_e;

  typedef enum logic [CODE_W-1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } order_e;

  // per-stage advance enables handed to each lane
  typedef struct packed {
    logic en_s1;
    logic en_s2;
  } lane_ctl_t;

  // what one lane found for its date
  typedef struct packed {
    logic            ok;
    logic [DN_W-1:0] day_num;
  } lane_res_t;

  // floor(x/100) for x < 25600 by reciprocal multiply (exact in this range)
  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W:0] x);
    logic [29:0] p;
    p = {15'd0, x} * 30'd20972;
    return p[28:21];
  endfunction

  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                         n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
      default:                      n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/dvdd_if.sv -----
// -----------------------------------------------------------------------------
// dvdd_if
// Valid/ready channels of the date check and day count unit.
// -----------------------------------------------------------------------------
interface dvdd_in_if;
  logic                        valid;
  logic                        ready;
  logic [dvdd_pkg::DAY_W-1:0]   start_day;
  logic [dvdd_pkg::MONTH_W-1:0] start_month;
  logic [dvdd_pkg::YEAR_W-1:0]  start_year;
  logic [dvdd_pkg::DAY_W-1:0]   end_day;
  logic [dvdd_pkg::MONTH_W-1:0] end_month;
  logic [dvdd_pkg::YEAR_W-1:0]  end_year;

  modport source (output valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, input ready);
  modport sink   (input valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, output ready);
endinterface

interface dvdd_out_if;
  logic                        valid;
  logic                        ready;
  logic [dvdd_pkg::COUNT_W-1:0] day_count;
  logic [dvdd_pkg::CODE_W-1:0]  status;
  logic [dvdd_pkg::CODE_W-1:0]  order;

  modport source (output valid, day_count, status, order, input ready);
  modport sink   (input valid, day_count, status, order, output ready);
endinterface

interface dvdd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dvdd_pkg::CFG_IDX_W-1:0] index;
  logic [dvdd_pkg::YEAR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dvdd_lane.sv -----
// -----------------------------------------------------------------------------
// dvdd_lane
// One date: range/month/day check and day number, two register stages.
// -----------------------------------------------------------------------------
module dvdd_lane (
  input  logic                          clk_i,
  input  dvdd_pkg::lane_ctl_t           ctl_i,
  input  logic [dvdd_pkg::DAY_W-1:0]    day_i,
  input  logic [dvdd_pkg::MONTH_W-1:0]  month_i,
  input  logic [dvdd_pkg::YEAR_W-1:0]   year_i,
  input  logic [dvdd_pkg::YEAR_W-1:0]   year_lo_i,
  input  logic [dvdd_pkg::YEAR_W-1:0]   year_hi_i,
  output dvdd_pkg::lane_res_t           res_o
);

  // stage 1: year quotients
  logic [dvdd_pkg::DAY_W-1:0]   day_q;
  logic [dvdd_pkg::MONTH_W-1:0] month_q;
  logic [dvdd_pkg::YEAR_W-1:0]  year_q;
  logic [dvdd_pkg::Q100_W-1:0]  qf100_q, qc100_q;
  logic [dvdd_pkg::Q400_W-1:0]  qc400_q;
  logic [dvdd_pkg::Q100_W-1:0]  qc400_full;

  assign qc400_full = dvdd_pkg::div100({1'b0, year_i} + 15'd399);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_s1) begin
      day_q   <= day_i;
      month_q <= month_i;
      year_q  <= year_i;
      qf100_q <= dvdd_pkg::div100({1'b0, year_i});
      qc100_q <= dvdd_pkg::div100({1'b0, year_i} + 15'd99);
      qc400_q <= qc400_full[dvdd_pkg::Q100_W-1:2];
    end
  end

  // stage 2: leap, validity, day number
  logic                      div100_by, leap, ok_d;
  logic [4:0]                mlen;
  logic [dvdd_pkg::DN_W-1:0] dn_d;
  logic [dvdd_pkg::YEAR_W:0] y_plus3;

  // ceil and floor of y/100 agree only when 100 divides y
  assign div100_by = (qc100_q == qf100_q);
  assign leap = div100_by ? (qf100_q[1:0] == 2'd0) : (year_q[1:0] == 2'd0);
  assign mlen = dvdd_pkg::month_len(month_q, leap);
  assign y_plus3 = {1'b0, year_q} + 15'd3;

  assign ok_d = (year_q >= year_lo_i) && (year_q <= year_hi_i)
             && (month_q != '0) && (month_q <= dvdd_pkg::MONTH_DEC)
             && (day_q != '0) && (day_q <= {1'b0, mlen});

  assign dn_d = (dvdd_pkg::DN_W'(year_q) * 23'd365)
              + dvdd_pkg::DN_W'(y_plus3[dvdd_pkg::YEAR_W:2])
              - dvdd_pkg::DN_W'(qc100_q)
              + dvdd_pkg::DN_W'(qc400_q)
              + dvdd_pkg::DN_W'(dvdd_pkg::days_before(month_q))
              + dvdd_pkg::DN_W'((month_q > dvdd_pkg::MONTH_FEB) && leap)
              + dvdd_pkg::DN_W'(day_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_s2) begin
      res_o.ok      <= ok_d;
      res_o.day_num <= dn_d;
    end
  end

endmodule

// ----- rtl/dvdd_merge.sv -----
// -----------------------------------------------------------------------------
// dvdd_merge
// Combines both lanes into status and saturated inclusive count; holds the
// output register.
// -----------------------------------------------------------------------------
module dvdd_merge (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  dvdd_pkg::lane_res_t           start_i,
  input  dvdd_pkg::lane_res_t           end_i,
  input  dvdd_pkg::order_e              order_i,
  output logic [dvdd_pkg::COUNT_W-1:0]  day_count_o,
  output dvdd_pkg::status_e             status_o,
  output dvdd_pkg::order_e              order_o
);

  logic [dvdd_pkg::DN_W-1:0]    span;
  logic [dvdd_pkg::COUNT_W-1:0] count_d;
  dvdd_pkg::status_e            status_d;

  assign span = end_i.day_num - start_i.day_num + 23'd1;

  always_comb begin
    count_d = '0;
    if (!start_i.ok) begin
      status_d = dvdd_pkg::ST_START_BAD;
    end else if (!end_i.ok) begin
      status_d = dvdd_pkg::ST_END_BAD;
    end else if (order_i == dvdd_pkg::ORD_EARLIER) begin
      status_d = dvdd_pkg::ST_END_BEFORE;
    end else begin
      status_d = dvdd_pkg::ST_OK;
      count_d  = span[dvdd_pkg::DN_W-1] ? dvdd_pkg::COUNT_MAX
                                         : span[dvdd_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      day_count_o <= count_d;
      status_o    <= status_d;
      order_o     <= order_i;
    end
  end

endmodule

// ----- rtl/date_validate_and_day_difference_unit.sv -----
// -----------------------------------------------------------------------------
// date_validate_and_day_difference_unit
// Gregorian check of a start and an end date, their order, and the
// inclusive day count between them.
// -----------------------------------------------------------------------------
//  channel  dir  payload                                   transfer
//  in_i     in   start/end day, month, year                valid & ready
//  out_o    out  day_count, status, order                  valid & ready
//  cfg_i    in   index (0 lowest year, 1 highest year), data  valid & ready
//
//  Two lanes (start, end) in parallel, three stages: year quotients, day
//  number and check, merge into the output register. One item per cycle
//  sustained while out_o is ready. Each stage moves when the next one is empty
//  or moving, so bubbles close up and a stalled output holds only what is
//  behind it. Reset empties the pipe and loads the year range 2022 to 2050.
// -----------------------------------------------------------------------------
module date_validate_and_day_difference_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvdd_in_if.sink    in_i,
  dvdd_out_if.source out_o,
  dvdd_cfg_if.sink   cfg_i
);

  logic [dvdd_pkg::YEAR_W-1:0] year_lo_q, year_hi_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_lo_q <= dvdd_pkg::YEAR_LO_RST;
      year_hi_q <= dvdd_pkg::YEAR_HI_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dvdd_pkg::REG_YEAR_LO: year_lo_q <= cfg_i.data;
        dvdd_pkg::REG_YEAR_HI: year_hi_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline occupancy
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  dvdd_pkg::lane_ctl_t ctl;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ctl.en_s1 = en1;
  assign ctl.en_s2 = en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // order compares the raw fields, year then month then day
  logic [dvdd_pkg::YEAR_W+9:0] skey, ekey;
  dvdd_pkg::order_e            ord_d, ord1_q, ord2_q;

  assign skey = {in_i.start_year, in_i.start_month, in_i.start_day};
  assign ekey = {in_i.end_year, in_i.end_month, in_i.end_day};

  always_comb begin
    if (ekey < skey)       ord_d = dvdd_pkg::ORD_EARLIER;
    else if (ekey == skey) ord_d = dvdd_pkg::ORD_EQUAL;
    else                   ord_d = dvdd_pkg::ORD_LATER;
  end

  always_ff @(posedge clk_i) begin
    if (en1) ord1_q <= ord_d;
    if (en2) ord2_q <= ord1_q;
  end

  dvdd_pkg::lane_res_t start_res, end_res;

  dvdd_lane u_lane_start (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .day_i     (in_i.start_day),
    .month_i   (in_i.start_month),
    .year_i    (in_i.start_year),
    .year_lo_i (year_lo_q),
    .year_hi_i (year_hi_q),
    .res_o     (start_res)
  );

  dvdd_lane u_lane_end (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .day_i     (in_i.end_day),
    .month_i   (in_i.end_month),
    .year_i    (in_i.end_year),
    .year_lo_i (year_lo_q),
    .year_hi_i (year_hi_q),
    .res_o     (end_res)
  );

  dvdd_pkg::status_e status;
  dvdd_pkg::order_e  order;

  dvdd_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (en3),
    .start_i     (start_res),
    .end_i       (end_res),
    .order_i     (ord2_q),
    .day_count_o (out_o.day_count),
    .status_o    (status),
    .order_o     (order)
  );

  assign out_o.valid  = v3_q;
  assign out_o.status = status;
  assign out_o.order  = order;

endmodule

// ----- tb/sv/dvdd_tb_pkg.sv -----
// -----------------------------------------------------------------------------
// dvdd_tb_pkg
// Scoreboard for the date check and day count unit: predicts status, order
// and inclusive day count of each accepted date pair and checks the results.
// -----------------------------------------------------------------------------
package dvdd_tb_pkg;
  import dvdd_pkg::*;

  typedef struct {
    logic [COUNT_W-1:0] day_count;
    status_e            status;
    order_e             order;
  } span_t;

  class date_span_scoreboard;
    logic [YEAR_W-1:0] year_lo;
    logic [YEAR_W-1:0] year_hi;
    span_t             expected_spans[$];
    int unsigned       failures;
    int unsigned       checked;
    int unsigned       saturated;
    int unsigned       by_status[4];

    function new();
      year_lo   = YEAR_LO_RST;
      year_hi   = YEAR_HI_RST;
      failures  = 0;
      checked   = 0;
      saturated = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    static function bit is_leap(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    static function int unsigned days_in_month(input int unsigned m, input int unsigned y);
      case (m)
        2:            return is_leap(y) ? 29 : 28;
        4, 6, 9, 11:  return 30;
        default:      return 31;
      endcase
    endfunction

    function bit date_valid(input int unsigned d, input int unsigned m, input int unsigned y);
      if (y < year_lo || y > year_hi) return 1'b0;
      if (m < 1 || m > 12) return 1'b0;
      return d >= 1 && d <= days_in_month(m, y);
    endfunction

    // day 1 is 1 Jan of year 0; only called on valid dates
    static function int unsigned serial_day(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
      int unsigned n;
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      for (int unsigned k = 1; k < m; k++) n += days_in_month(k, y);
      return n + d;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [YEAR_W-1:0] data);
      if (idx == REG_YEAR_LO) year_lo = data;
      else if (idx == REG_YEAR_HI) year_hi = data;
    endfunction

    function int unsigned pending();
      return expected_spans.size();
    endfunction

    function void record_dates(input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm,
                               input logic [YEAR_W-1:0] sy, input logic [DAY_W-1:0] ed,
                               input logic [MONTH_W-1:0] em, input logic [YEAR_W-1:0] ey);
      span_t       s;
      logic [23:0] start_key;
      logic [23:0] end_key;
      int unsigned span;
      start_key   = {sy, sm, sd};
      end_key     = {ey, em, ed};
      s.day_count = '0;
      // order looks at raw fields, valid or not
      if (end_key < start_key) s.order = ORD_EARLIER;
      else if (end_key == start_key) s.order = ORD_EQUAL;
      else s.order = ORD_LATER;
      if (!date_valid(sd, sm, sy)) s.status = ST_START_BAD;
      else if (!date_valid(ed, em, ey)) s.status = ST_END_BAD;
      else if (s.order == ORD_EARLIER) s.status = ST_END_BEFORE;
      else begin
        s.status = ST_OK;
        span = serial_day(ed, em, ey) - serial_day(sd, sm, sy) + 1;
        if (span > COUNT_MAX) begin
          s.day_count = COUNT_MAX;
          saturated++;
        end else begin
          s.day_count = span[COUNT_W-1:0];
        end
      end
      expected_spans.push_back(s);
    endfunction

    function void check_span(input logic [COUNT_W-1:0] day_count,
                             input logic [CODE_W-1:0] status, input logic [CODE_W-1:0] order);
      span_t s;
      if (expected_spans.size() == 0) begin
        $error("unexpected result: day_count %0d status %0d order %0d",
               day_count, status, order);
        failures++;
        return;
      end
      s = expected_spans.pop_front();
      checked++;
      by_status[s.status]++;
      if (day_count !== s.day_count) begin
        $error("day_count: expected %0d, got %0d", s.day_count, day_count);
        failures++;
      end
      if (status !== s.status) begin
        $error("status: expected %0d (%s), got %0d", s.status, s.status.name(), status);
        failures++;
      end
      if (order !== s.order) begin
        $error("order: expected %0d (%s), got %0d", s.order, s.order.name(), order);
        failures++;
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/date_validate_and_day_difference_unit_test.sv -----
// -----------------------------------------------------------------------------
// date_validate_and_day_difference_unit_test
// Drives date pairs through the unit under several year ranges, with random
// gaps and output stalls, and checks every result against the scoreboard.
// -----------------------------------------------------------------------------
module date_validate_and_day_difference_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dvdd_pkg::*;
  import dvdd_tb_pkg::*;

  localparam int unsigned PIPE_DEPTH  = 3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int unsigned {PICK_VALID, PICK_EDGE} pick_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  dvdd_in_if  in_bus ();
  dvdd_out_if out_bus ();
  dvdd_cfg_if cfg_bus ();

  date_validate_and_day_difference_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  date_span_scoreboard sb;
  bit                  calm;
  int unsigned         cycles;
  int unsigned         pairs_sent;
  int unsigned         ranges_used;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_span(out_bus.day_count, out_bus.status, out_bus.order);
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output stalls
  initial begin
    int unsigned n;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = idle_gap();
      if (n != 0) begin
        out_bus.ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_bus.ready = 1'b1;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [YEAR_W-1:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // valid stays high at return; drain() or the next gap lowers it
  task automatic send_dates(input logic [DAY_W-1:0] sd, input logic [MONTH_W-1:0] sm,
                            input logic [YEAR_W-1:0] sy, input logic [DAY_W-1:0] ed,
                            input logic [MONTH_W-1:0] em, input logic [YEAR_W-1:0] ey);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       = 1'b1;
    in_bus.start_day   = sd;
    in_bus.start_month = sm;
    in_bus.start_year  = sy;
    in_bus.end_day     = ed;
    in_bus.end_month   = em;
    in_bus.end_year    = ey;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.record_dates(sd, sm, sy, ed, em, ey);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
  endtask

  task automatic set_range(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi,
                           input bit no_idle);
    drain();
    write_reg(REG_YEAR_LO, lo);
    write_reg(REG_YEAR_HI, hi);
    calm = no_idle;
    ranges_used++;
  endtask

  function automatic void pick_date(input pick_e kind, output logic [DAY_W-1:0] d,
                                    output logic [MONTH_W-1:0] m,
                                    output logic [YEAR_W-1:0] y);
    int unsigned len;
    if (kind == PICK_VALID) begin
      y = $urandom_range(sb.year_hi, sb.year_lo);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, date_span_scoreboard::days_in_month(m, y));
    end else begin
      // around the range bounds and month ends
      case ($urandom_range(0, 3))
        0:       y = sb.year_lo - 1;
        1:       y = sb.year_lo;
        2:       y = sb.year_hi;
        default: y = sb.year_hi + 1;
      endcase
      m   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      len = date_span_scoreboard::days_in_month(m, y);
      case ($urandom_range(0, 4))
        0:       d = 0;
        1:       d = 1;
        2:       d = len - 1;
        3:       d = len;
        default: d = len + 1;
      endcase
    end
  endfunction

  task automatic send_random();
    logic [DAY_W-1:0]   sd, ed;
    logic [MONTH_W-1:0] sm, em;
    logic [YEAR_W-1:0]  sy, ey;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      pick_date(PICK_VALID, sd, sm, sy);
      pick_date(PICK_VALID, ed, em, ey);
      // mostly keep end after start so counts get exercised
      if ($urandom_range(0, 2) != 0 && {ey, em, ed} < {sy, sm, sd})
        {sd, sm, sy, ed, em, ey} = {ed, em, ey, sd, sm, sy};
    end else if (r < 57) begin
      pick_date(PICK_VALID, sd, sm, sy);
      {ed, em, ey} = {sd, sm, sy};
      case ($urandom_range(0, 3))
        0:       ed = ed + 1;
        1:       ed = ed - 1;
        2:       ey = ey + 1;
        default: ;
      endcase
    end else if (r < 77) begin
      pick_date(($urandom_range(0, 1) == 0) ? PICK_VALID : PICK_EDGE, sd, sm, sy);
      pick_date(PICK_EDGE, ed, em, ey);
      if ($urandom_range(0, 1) == 0)
        {sd, sm, sy, ed, em, ey} = {ed, em, ey, sd, sm, sy};
    end else begin
      sd = $urandom;
      sm = $urandom;
      sy = $urandom;
      ed = $urandom;
      em = $urandom;
      ey = $urandom;
    end
    send_dates(sd, sm, sy, ed, em, ey);
  endtask

  task automatic send_batch(input int unsigned n);
    repeat (n) send_random();
  endtask

  initial begin
    sb                 = new();
    calm               = 1'b0;
    cycles             = 0;
    pairs_sent         = 0;
    ranges_used        = 1;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.start_day   = '0;
    in_bus.start_month = '0;
    in_bus.start_year  = '0;
    in_bus.end_day     = '0;
    in_bus.end_month   = '0;
    in_bus.end_year    = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_YEAR_LO;
    cfg_bus.data       = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset range 2022..2050
    send_dates(15, 6, 2030, 15, 6, 2030);
    send_dates(1, 1, 2022, 31, 12, 2050);
    send_dates(29, 2, 2024, 1, 3, 2024);
    send_dates(29, 2, 2023, 1, 3, 2023);
    send_dates(30, 4, 2030, 31, 4, 2030);
    send_dates(1, 1, 2030, 31, 12, 2029);
    send_dates(0, 0, 2030, 1, 13, 2030);
    send_dates(31, 12, 2021, 1, 1, 2051);
    send_dates(63, 15, 16383, 63, 15, 16383);
    send_dates(0, 0, 0, 0, 0, 0);
    send_dates(1, 1, 2050, 1, 1, 2022);
    send_dates(31, 1, 2030, 1, 2, 2030);
    send_batch(120);

    // widest range: year zero, century rules, saturation
    set_range(0, 16383, 1'b0);
    send_dates(1, 1, 0, 31, 12, 16383);
    send_dates(29, 2, 0, 1, 3, 0);
    send_dates(29, 2, 1900, 1, 3, 1900);
    send_dates(28, 2, 2100, 1, 3, 2100);
    send_dates(29, 2, 2100, 1, 3, 2100);
    send_dates(29, 2, 2000, 29, 2, 2400);
    send_batch(100);

    set_range(1582, 2400, 1'b1);
    send_batch(100);

    set_range(2000, 2000, 1'b0);
    send_batch(60);

    // lower bound above upper bound: nothing valid
    set_range(2050, 2022, 1'b0);
    send_dates(15, 6, 2030, 15, 6, 2030);
    send_dates(10, 10, 2030, 1, 1, 2000);
    send_batch(40);

    set_range(0, 0, 1'b0);
    send_batch(30);

    set_range(16383, 16383, 1'b0);
    send_batch(30);

    set_range(1, 9999, 1'b0);
    // writes to unused indexes must leave the range alone
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_batch(120);

    drain();
    repeat (2 * PIPE_DEPTH) @(negedge clk_i);
    $display("Checked %0d results from %0d date pairs over %0d year ranges, %0d saturated",
             sb.checked, pairs_sent, ranges_used, sb.saturated);
    $display("Status mix: ok %0d, start invalid %0d, end invalid %0d, end before start %0d",
             sb.by_status[ST_OK], sb.by_status[ST_START_BAD], sb.by_status[ST_END_BAD],
             sb.by_status[ST_END_BEFORE]);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
